// ===== rtl/clb_pkg.sv =====
// Shared types and constants for the C source line breaker.
`default_nettype none

package clb_pkg;

    // Source beat: one byte or an end-of-stream marker.
    typedef struct packed {
        logic [7:0] in_char;
        logic       end_of_stream;
    } clb_src_t;

    // Formatted beat.
    typedef struct packed {
        logic [7:0] out_char;
        logic       char_valid;
        logic       last;
        logic [2:0] status;
        logic       finished;
    } clb_fmt_t;

    // Work for the back end: up to three result beats from one source beat.
    typedef struct packed {
        logic [2:0][7:0] ch;          // ch[0] goes out first
        logic [1:0]      beats;       // 1 to 3
        logic            data_valid;  // 0 only for the end-of-stream beat
        logic [2:0]      status;      // carried on the final beat
        logic            finished;
    } clb_job_t;

    typedef enum logic [2:0] {
        MODE_NORMAL     = 3'd0,
        MODE_COMMA      = 3'd1,
        MODE_CHAR_FIRST = 3'd2,
        MODE_CHAR_ESC   = 3'd3,
        MODE_CHAR_CLOSE = 3'd4,
        MODE_STR        = 3'd5,
        MODE_STR_ESC    = 3'd6,
        MODE_HASH       = 3'd7
    } clb_mode_t;

    typedef enum logic [2:0] {
        ST_OK           = 3'd0,
        ST_CHAR_NEWLINE = 3'd1,
        ST_CHAR_EMPTY   = 3'd2,
        ST_CHAR_UNCLOSE = 3'd3,
        ST_STR_NEWLINE  = 3'd4,
        ST_EOS_COMMA    = 3'd5,
        ST_EOS_CHAR     = 3'd6,
        ST_EOS_STR      = 3'd7
    } clb_status_t;

    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_SEVEN  = 8'h37;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_QMARK  = 8'h3F;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;

endpackage

`default_nettype wire

// ===== rtl/clb_scanner.sv =====
// Front end: scanner state machine, turns each source beat that yields output into a job.
`default_nettype none

module clb_scanner
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              src_valid,
    output logic                   src_stall,
    input  wire clb_pkg::clb_src_t src_data,
    input  wire logic              queue_full,
    output logic                   push,
    output clb_pkg::clb_job_t      push_job
);

    clb_pkg::clb_mode_t mode_reg, mode_next;
    logic               als_reg, als_next;     // output at line start
    logic [1:0]         oct_reg, oct_next;     // octal digits in escape

    // result of scanning the current byte
    clb_pkg::clb_mode_t mode_a;
    logic               als_a;
    logic [1:0]         oct_a;
    logic [2:0][7:0]    ch_a;
    logic [1:0]         n_a;
    logic [2:0]         st_a;
    logic [2:0]         eos_st;

    logic [7:0] c;
    logic       accept;
    logic       eos;

    assign c         = src_data.in_char;
    assign eos       = src_data.end_of_stream;
    assign src_stall = queue_full;
    assign accept    = src_valid && !queue_full;

    always_comb
    begin
        logic run_normal;
        logic run_close;
        logic run_str;
        logic is_oct;

        mode_a     = mode_reg;
        als_a      = als_reg;
        oct_a      = oct_reg;
        ch_a       = '0;
        n_a        = 2'd0;
        st_a       = clb_pkg::ST_OK;
        run_normal = 1'b0;
        run_close  = 1'b0;
        run_str    = 1'b0;
        is_oct     = (c >= clb_pkg::CH_ZERO) && (c <= clb_pkg::CH_SEVEN);

        case (mode_reg)
            clb_pkg::MODE_COMMA:
            begin
                if (c != clb_pkg::CH_SPACE && c != clb_pkg::CH_TAB)
                begin
                    mode_a = clb_pkg::MODE_NORMAL;
                    if (c == clb_pkg::CH_LF)
                    begin
                        ch_a[n_a] = c;
                        n_a       = n_a + 2'd1;
                        als_a     = 1'b1;
                    end
                    else
                    begin
                        ch_a[n_a]  = clb_pkg::CH_SPACE;
                        n_a        = n_a + 2'd1;
                        run_normal = 1'b1;
                    end
                end
            end
            clb_pkg::MODE_CHAR_FIRST:
            begin
                ch_a[n_a] = c;
                n_a       = n_a + 2'd1;
                if (c == clb_pkg::CH_LF)
                begin
                    st_a   = clb_pkg::ST_CHAR_NEWLINE;
                    als_a  = 1'b1;
                    mode_a = clb_pkg::MODE_NORMAL;
                end
                else if (c == clb_pkg::CH_SQUOTE)
                begin
                    st_a   = clb_pkg::ST_CHAR_EMPTY;
                    mode_a = clb_pkg::MODE_NORMAL;
                end
                else if (c == clb_pkg::CH_BSLASH)
                begin
                    oct_a  = 2'd0;
                    mode_a = clb_pkg::MODE_CHAR_ESC;
                end
                else
                begin
                    mode_a = clb_pkg::MODE_CHAR_CLOSE;
                end
            end
            clb_pkg::MODE_CHAR_ESC, clb_pkg::MODE_STR_ESC:
            begin
                if (is_oct)
                begin
                    ch_a[n_a] = c;
                    n_a       = n_a + 2'd1;
                    if (oct_reg >= 2'd2)
                    begin
                        oct_a  = 2'd0;
                        mode_a = (mode_reg == clb_pkg::MODE_CHAR_ESC) ?
                                 clb_pkg::MODE_CHAR_CLOSE : clb_pkg::MODE_STR;
                    end
                    else
                    begin
                        oct_a = oct_reg + 2'd1;
                    end
                end
                else if (oct_reg == 2'd0)
                begin
                    ch_a[n_a] = c;
                    n_a       = n_a + 2'd1;
                    mode_a    = (mode_reg == clb_pkg::MODE_CHAR_ESC) ?
                                clb_pkg::MODE_CHAR_CLOSE : clb_pkg::MODE_STR;
                end
                else
                begin
                    // escape ends early, byte belongs to the literal body
                    oct_a = 2'd0;
                    if (mode_reg == clb_pkg::MODE_CHAR_ESC)
                        run_close = 1'b1;
                    else
                        run_str = 1'b1;
                end
            end
            clb_pkg::MODE_CHAR_CLOSE:
            begin
                run_close = 1'b1;
            end
            clb_pkg::MODE_STR:
            begin
                run_str = 1'b1;
            end
            clb_pkg::MODE_HASH:
            begin
                if (c == clb_pkg::CH_LF)
                    mode_a = clb_pkg::MODE_NORMAL;
            end
            default:
            begin
                mode_a     = clb_pkg::MODE_NORMAL;
                run_normal = 1'b1;
            end
        endcase

        if (run_normal)
        begin
            case (c)
                clb_pkg::CH_FF:
                begin
                end
                clb_pkg::CH_COMMA:
                begin
                    ch_a[n_a] = c;
                    n_a       = n_a + 2'd1;
                    mode_a    = clb_pkg::MODE_COMMA;
                end
                clb_pkg::CH_SEMI, clb_pkg::CH_COLON, clb_pkg::CH_QMARK,
                clb_pkg::CH_RBRACE:
                begin
                    ch_a[n_a] = c;
                    n_a       = n_a + 2'd1;
                    ch_a[n_a] = clb_pkg::CH_LF;
                    n_a       = n_a + 2'd1;
                    als_a     = 1'b1;
                end
                clb_pkg::CH_LF:
                begin
                    if (!als_reg)
                    begin
                        ch_a[n_a] = clb_pkg::CH_LF;
                        n_a       = n_a + 2'd1;
                        als_a     = 1'b1;
                    end
                end
                clb_pkg::CH_SQUOTE:
                begin
                    ch_a[n_a] = c;
                    n_a       = n_a + 2'd1;
                    mode_a    = clb_pkg::MODE_CHAR_FIRST;
                end
                clb_pkg::CH_DQUOTE:
                begin
                    als_a     = 1'b0;
                    ch_a[n_a] = c;
                    n_a       = n_a + 2'd1;
                    mode_a    = clb_pkg::MODE_STR;
                end
                clb_pkg::CH_HASH:
                begin
                    if (als_reg)
                    begin
                        mode_a = clb_pkg::MODE_HASH;
                    end
                    else
                    begin
                        ch_a[n_a] = c;
                        n_a       = n_a + 2'd1;
                    end
                end
                clb_pkg::CH_LBRACE:
                begin
                    if (!als_reg)
                    begin
                        ch_a[n_a] = clb_pkg::CH_LF;
                        n_a       = n_a + 2'd1;
                    end
                    als_a     = 1'b0;
                    ch_a[n_a] = c;
                    n_a       = n_a + 2'd1;
                end
                default:
                begin
                    als_a     = 1'b0;
                    ch_a[n_a] = c;
                    n_a       = n_a + 2'd1;
                end
            endcase
        end

        if (run_close)
        begin
            ch_a[n_a] = c;
            n_a       = n_a + 2'd1;
            if (c != clb_pkg::CH_SQUOTE)
                st_a = clb_pkg::ST_CHAR_UNCLOSE;
            mode_a = clb_pkg::MODE_NORMAL;
        end

        if (run_str)
        begin
            ch_a[n_a] = c;
            n_a       = n_a + 2'd1;
            if (c == clb_pkg::CH_LF)
            begin
                st_a   = clb_pkg::ST_STR_NEWLINE;
                als_a  = 1'b1;
                mode_a = clb_pkg::MODE_NORMAL;
            end
            else if (c == clb_pkg::CH_DQUOTE)
            begin
                mode_a = clb_pkg::MODE_NORMAL;
            end
            else if (c == clb_pkg::CH_BSLASH)
            begin
                oct_a  = 2'd0;
                mode_a = clb_pkg::MODE_STR_ESC;
            end
        end
    end

    always_comb
    begin
        case (mode_reg)
            clb_pkg::MODE_COMMA:
                eos_st = clb_pkg::ST_EOS_COMMA;
            clb_pkg::MODE_CHAR_FIRST, clb_pkg::MODE_CHAR_ESC, clb_pkg::MODE_CHAR_CLOSE:
                eos_st = clb_pkg::ST_EOS_CHAR;
            clb_pkg::MODE_STR, clb_pkg::MODE_STR_ESC:
                eos_st = clb_pkg::ST_EOS_STR;
            default:
                eos_st = clb_pkg::ST_OK;
        endcase
    end

    // next state
    always_comb
    begin
        mode_next = mode_reg;
        als_next  = als_reg;
        oct_next  = oct_reg;
        if (accept)
        begin
            if (eos)
            begin
                mode_next = clb_pkg::MODE_NORMAL;
                als_next  = 1'b1;
                oct_next  = 2'd0;
            end
            else
            begin
                mode_next = mode_a;
                als_next  = als_a;
                oct_next  = oct_a;
            end
        end
    end

    // outputs: one job per source beat that yields anything
    always_comb
    begin
        push_job = '0;
        if (eos)
        begin
            push_job.beats      = 2'd1;
            push_job.data_valid = 1'b0;
            push_job.status     = eos_st;
            push_job.finished   = 1'b1;
        end
        else
        begin
            push_job.ch         = ch_a;
            push_job.beats      = n_a;
            push_job.data_valid = 1'b1;
            push_job.status     = st_a;
            push_job.finished   = 1'b0;
        end
        push = accept && (eos || n_a != 2'd0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= clb_pkg::MODE_NORMAL;
            als_reg  <= 1'b1;
            oct_reg  <= 2'd0;
        end
        else
        begin
            mode_reg <= mode_next;
            als_reg  <= als_next;
            oct_reg  <= oct_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/clb_queue.sv =====
// Job queue between scanner and emitter.
`default_nettype none

module clb_queue
#(
    parameter int DEPTH = 4
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire clb_pkg::clb_job_t push_job,
    output logic                   full,
    input  wire logic              pop,
    output clb_pkg::clb_job_t      pop_job,
    output logic                   not_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    clb_pkg::clb_job_t slot_reg [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_job   = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        if (push && !pop)
            count_next = count_reg + CNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/clb_emitter.sv =====
// Back end: plays out each job one output beat per cycle while fmt_stall is low.
`default_nettype none

module clb_emitter
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              job_valid,
    input  wire clb_pkg::clb_job_t job,
    output logic                   pop,
    output logic                   fmt_valid,
    input  wire logic              fmt_stall,
    output clb_pkg::clb_fmt_t      fmt_data
);

    clb_pkg::clb_job_t job_reg, job_next;
    logic [1:0]        idx_reg, idx_next;
    logic              busy_reg, busy_next;

    logic advance;
    logic at_end;

    assign advance = busy_reg && !fmt_stall;
    assign at_end  = (idx_reg == job_reg.beats - 2'd1);
    assign pop     = job_valid && (!busy_reg || (advance && at_end));

    always_comb
    begin
        job_next  = job_reg;
        idx_next  = idx_reg;
        busy_next = busy_reg;
        if (pop)
        begin
            job_next  = job;
            idx_next  = 2'd0;
            busy_next = 1'b1;
        end
        else if (advance)
        begin
            if (at_end)
                busy_next = 1'b0;
            else
                idx_next = idx_reg + 2'd1;
        end
    end

    always_comb
    begin
        fmt_valid           = busy_reg;
        fmt_data.out_char   = job_reg.data_valid ? job_reg.ch[idx_reg] : 8'd0;
        fmt_data.char_valid = job_reg.data_valid;
        fmt_data.last       = at_end;
        fmt_data.status     = at_end ? job_reg.status : clb_pkg::ST_OK;
        fmt_data.finished   = job_reg.finished;
    end

    always_ff @(posedge clk)
    begin
        job_reg <= job_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg  <= 2'd0;
            busy_reg <= 1'b0;
        end
        else
        begin
            idx_reg  <= idx_next;
            busy_reg <= busy_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/c_source_line_breaker.sv =====
// Top level of the C source line breaker: scanner, job queue, emitter.
//
//  channel | dir | handshake          | beat
//  --------+-----+--------------------+-----------------------------------------
//  src     | in  | src_valid/src_stall | clb_src_t: in_char, end_of_stream
//  fmt     | out | fmt_valid/fmt_stall | clb_fmt_t: out_char, char_valid, last,
//          |     |                    |            status, finished
//
//  The scanner takes one source beat per cycle whenever the job queue has room;
//  scanner state updates in the cycle of acceptance.
//  A source beat yields zero to three output beats; the emitter sends one per
//  cycle while fmt_stall is low, and the queue (QUEUE_DEPTH jobs) soaks up the
//  difference. From src accept, a job passes the queue slot and then the
//  emitter job register before its first fmt beat.
//  Reset (rst_n low, async) puts the scanner in normal text at line start and
//  empties queue and emitter. src_stall is high only while the queue is full.
`default_nettype none

module c_source_line_breaker
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              src_valid,
    output logic                   src_stall,
    input  wire clb_pkg::clb_src_t src_data,
    output logic                   fmt_valid,
    input  wire logic              fmt_stall,
    output clb_pkg::clb_fmt_t      fmt_data
);

    logic              queue_full;
    logic              push;
    clb_pkg::clb_job_t push_job;
    logic              pop;
    clb_pkg::clb_job_t pop_job;
    logic              job_valid;

    // Front: classify byte, update scanner state, build job.
    clb_scanner u_scanner
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .src_valid  (src_valid),
        .src_stall  (src_stall),
        .src_data   (src_data),
        .queue_full (queue_full),
        .push       (push),
        .push_job   (push_job)
    );

    // Jobs wait here so each side stalls on its own.
    clb_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_job  (push_job),
        .full      (queue_full),
        .pop       (pop),
        .pop_job   (pop_job),
        .not_empty (job_valid)
    );

    // Back: one output beat per cycle while fmt_stall is low, last/status on the final beat of a job.
    clb_emitter u_emitter
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (job_valid),
        .job       (pop_job),
        .pop       (pop),
        .fmt_valid (fmt_valid),
        .fmt_stall (fmt_stall),
        .fmt_data  (fmt_data)
    );

endmodule

`default_nettype wire

// ===== tb/c_source_line_breaker_tb.sv =====
// Self-checking testbench for the C source line breaker: directed and random byte streams.
module c_source_line_breaker_tb;

    // Generous wall for the whole run.
    localparam int RUN_LIMIT   = 2000000;
    localparam int DRAIN_LIMIT = 50000;
    localparam int RANDOM_BEATS = 245;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              src_valid = 1'b0;
    logic              src_stall;
    clb_pkg::clb_src_t src_data = '0;
    logic              fmt_valid;
    logic              fmt_stall = 1'b0;
    clb_pkg::clb_fmt_t fmt_data;

    c_source_line_breaker dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (src_valid),
        .src_stall (src_stall),
        .src_data  (src_data),
        .fmt_valid (fmt_valid),
        .fmt_stall (fmt_stall),
        .fmt_data  (fmt_data)
    );

    always #2 clk = ~clk;

    // Shared run state.
    clb_pkg::clb_fmt_t pending_fmt[$];   // formatted beats still owed by the block
    int       fails = 0;
    int       items_sent = 0;
    bit       idle_on = 1'b1;   // random gaps on both channels when set
    int       stall_left = 0;

    // ---------------------------------------------------------------
    // Formatter prediction: scanner state and the bytes of one step.
    // ---------------------------------------------------------------
    clb_pkg::clb_mode_t   cur_mode = clb_pkg::MODE_NORMAL;
    logic                 line_start = 1'b1;
    logic [1:0]           octal_seen = 2'd0;
    logic [7:0]           emit_ch[3];
    int                   emit_n;
    clb_pkg::clb_status_t emit_status;

    // At most three bytes leave per source byte; anything more is dropped.
    function automatic void emit(input logic [7:0] c);
        if (emit_n < 3)
        begin
            emit_ch[emit_n] = c;
            emit_n++;
        end
    endfunction

    function automatic bit is_octal(input logic [7:0] c);
        return c >= clb_pkg::CH_ZERO && c <= clb_pkg::CH_SEVEN;
    endfunction

    // Byte in plain code, outside any literal.
    function automatic void plain_text(input logic [7:0] c);
        case (c)
            clb_pkg::CH_FF: ;
            clb_pkg::CH_COMMA:
            begin
                emit(c);
                cur_mode = clb_pkg::MODE_COMMA;
            end
            clb_pkg::CH_SEMI, clb_pkg::CH_COLON, clb_pkg::CH_QMARK, clb_pkg::CH_RBRACE:
            begin
                emit(c);
                emit(clb_pkg::CH_LF);
                line_start = 1'b1;
            end
            clb_pkg::CH_LF:
            begin
                if (!line_start)
                begin
                    emit(clb_pkg::CH_LF);
                    line_start = 1'b1;
                end
            end
            clb_pkg::CH_SQUOTE:
            begin
                emit(c);
                cur_mode = clb_pkg::MODE_CHAR_FIRST;
            end
            clb_pkg::CH_DQUOTE:
            begin
                line_start = 1'b0;
                emit(c);
                cur_mode = clb_pkg::MODE_STR;
            end
            clb_pkg::CH_HASH:
            begin
                if (line_start)
                    cur_mode = clb_pkg::MODE_HASH;
                else
                    emit(c);
            end
            clb_pkg::CH_LBRACE:
            begin
                if (!line_start)
                    emit(clb_pkg::CH_LF);
                line_start = 1'b0;
                emit(c);
            end
            default:
            begin
                line_start = 1'b0;
                emit(c);
            end
        endcase
    endfunction

    // Byte that should close a char literal.
    function automatic void char_close(input logic [7:0] c);
        emit(c);
        if (c != clb_pkg::CH_SQUOTE)
            emit_status = clb_pkg::ST_CHAR_UNCLOSE;
        cur_mode = clb_pkg::MODE_NORMAL;
    endfunction

    function automatic void string_text(input logic [7:0] c);
        emit(c);
        if (c == clb_pkg::CH_LF)
        begin
            emit_status = clb_pkg::ST_STR_NEWLINE;
            line_start = 1'b1;
            cur_mode = clb_pkg::MODE_NORMAL;
        end
        else if (c == clb_pkg::CH_DQUOTE)
            cur_mode = clb_pkg::MODE_NORMAL;
        else if (c == clb_pkg::CH_BSLASH)
        begin
            octal_seen = 2'd0;
            cur_mode = clb_pkg::MODE_STR_ESC;
        end
    endfunction

    // Backslash escape; returns 1 when c ended the escape and still has to be
    // handled as an ordinary literal byte.
    function automatic bit escape_ends(input logic [7:0] c,
                                       input clb_pkg::clb_mode_t back_to);
        if (is_octal(c))
        begin
            emit(c);
            if (octal_seen >= 2'd2)
            begin
                octal_seen = 2'd0;
                cur_mode = back_to;
            end
            else
                octal_seen = octal_seen + 2'd1;
            return 1'b0;
        end
        if (octal_seen == 2'd0)
        begin
            emit(c);
            cur_mode = back_to;
            return 1'b0;
        end
        octal_seen = 2'd0;
        cur_mode = back_to;
        return 1'b1;
    endfunction

    // Works out the formatted beats of one accepted source beat.
    function automatic void format_byte(input clb_pkg::clb_src_t b);
        clb_pkg::clb_fmt_t r;
        logic [7:0]        c;
        int                k;
        c = b.in_char;
        emit_n = 0;
        emit_status = clb_pkg::ST_OK;
        if (b.end_of_stream)
        begin
            r = '0;
            r.last = 1'b1;
            r.finished = 1'b1;
            case (cur_mode)
                clb_pkg::MODE_COMMA:
                    r.status = clb_pkg::ST_EOS_COMMA;
                clb_pkg::MODE_CHAR_FIRST, clb_pkg::MODE_CHAR_ESC, clb_pkg::MODE_CHAR_CLOSE:
                    r.status = clb_pkg::ST_EOS_CHAR;
                clb_pkg::MODE_STR, clb_pkg::MODE_STR_ESC:
                    r.status = clb_pkg::ST_EOS_STR;
                default:
                    r.status = clb_pkg::ST_OK;
            endcase
            pending_fmt.push_back(r);
            cur_mode = clb_pkg::MODE_NORMAL;
            line_start = 1'b1;
            octal_seen = 2'd0;
            return;
        end
        case (cur_mode)
            clb_pkg::MODE_COMMA:
            begin
                // blanks after a comma collapse into the one space below
                if (c != clb_pkg::CH_SPACE && c != clb_pkg::CH_TAB)
                begin
                    cur_mode = clb_pkg::MODE_NORMAL;
                    if (c == clb_pkg::CH_LF)
                    begin
                        emit(c);
                        line_start = 1'b1;
                    end
                    else
                    begin
                        emit(clb_pkg::CH_SPACE);
                        plain_text(c);
                    end
                end
            end
            clb_pkg::MODE_CHAR_FIRST:
            begin
                emit(c);
                if (c == clb_pkg::CH_LF)
                begin
                    emit_status = clb_pkg::ST_CHAR_NEWLINE;
                    line_start = 1'b1;
                    cur_mode = clb_pkg::MODE_NORMAL;
                end
                else if (c == clb_pkg::CH_SQUOTE)
                begin
                    emit_status = clb_pkg::ST_CHAR_EMPTY;
                    cur_mode = clb_pkg::MODE_NORMAL;
                end
                else if (c == clb_pkg::CH_BSLASH)
                begin
                    octal_seen = 2'd0;
                    cur_mode = clb_pkg::MODE_CHAR_ESC;
                end
                else
                    cur_mode = clb_pkg::MODE_CHAR_CLOSE;
            end
            clb_pkg::MODE_CHAR_ESC:
            begin
                if (escape_ends(c, clb_pkg::MODE_CHAR_CLOSE))
                    char_close(c);
            end
            clb_pkg::MODE_CHAR_CLOSE:
                char_close(c);
            clb_pkg::MODE_STR:
                string_text(c);
            clb_pkg::MODE_STR_ESC:
            begin
                if (escape_ends(c, clb_pkg::MODE_STR))
                    string_text(c);
            end
            clb_pkg::MODE_HASH:
            begin
                if (c == clb_pkg::CH_LF)
                    cur_mode = clb_pkg::MODE_NORMAL;
            end
            default:
            begin
                cur_mode = clb_pkg::MODE_NORMAL;
                plain_text(c);
            end
        endcase
        for (k = 0; k < emit_n; k++)
        begin
            r = '0;
            r.out_char = emit_ch[k];
            r.char_valid = 1'b1;
            r.last = (k == emit_n - 1);
            r.status = (k == emit_n - 1) ? emit_status : clb_pkg::ST_OK;
            pending_fmt.push_back(r);
        end
    endfunction

    // ---------------------------------------------------------------
    // Idling: mostly short gaps, now and then a long one.
    // ---------------------------------------------------------------
    function automatic int idle_len();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(8, 30);
        return $urandom_range(1, 3);
    endfunction

    // Output side: stall bursts while idling is enabled.
    always @(posedge clk)
    begin
        if (stall_left == 0 && idle_on && $urandom_range(0, 3) == 0)
            stall_left = idle_len();
        fmt_stall <= (stall_left != 0);
        if (stall_left != 0)
            stall_left--;
    end

    // ---------------------------------------------------------------
    // Result checking: each accepted beat against the oldest prediction.
    // ---------------------------------------------------------------
    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fails++;
        end
    endfunction

    always @(posedge clk)
    begin : check_fmt
        clb_pkg::clb_fmt_t want;
        if (rst_n && fmt_valid && !fmt_stall)
        begin
            if (pending_fmt.size() == 0)
            begin
                $error("unexpected beat: out_char %0h char_valid %0b finished %0b",
                       fmt_data.out_char, fmt_data.char_valid, fmt_data.finished);
                fails++;
            end
            else
            begin
                want = pending_fmt.pop_front();
                check_field("out_char",   want.out_char,   fmt_data.out_char);
                check_field("char_valid", 8'(want.char_valid), 8'(fmt_data.char_valid));
                check_field("last",       8'(want.last),       8'(fmt_data.last));
                check_field("status",     8'(want.status),     8'(fmt_data.status));
                check_field("finished",   8'(want.finished),   8'(fmt_data.finished));
            end
        end
    end

    // ---------------------------------------------------------------
    // Source side.
    // ---------------------------------------------------------------

    // Sends one beat; called at a rising edge, returns at the accepting edge.
    // Valid stays high into the next call unless a gap is taken there.
    task automatic send_beat(input logic [7:0] c, input logic eos);
        int                gap;
        clb_pkg::clb_src_t b;
        b.in_char = c;
        b.end_of_stream = eos;
        gap = (idle_on && $urandom_range(0, 2) == 0) ? idle_len() : 0;
        if (gap != 0)
        begin
            src_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        src_valid <= 1'b1;
        src_data <= b;
        @(posedge clk);
        while (src_stall)
            @(posedge clk);
        items_sent++;
        format_byte(b);
    endtask

    task automatic send_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            send_beat(s[i], 1'b0);
    endtask

    // End marker; the byte lane carries junk that must be ignored.
    task automatic end_stream();
        send_beat(8'($urandom_range(0, 255)), 1'b1);
    endtask

    function automatic logic [7:0] word_byte();
        case ($urandom_range(0, 2))
            0:       return 8'h61 + 8'($urandom_range(0, 25));
            1:       return 8'h41 + 8'($urandom_range(0, 25));
            default: return clb_pkg::CH_ZERO + 8'($urandom_range(0, 9));
        endcase
    endfunction

    function automatic logic [7:0] blank_byte();
        return $urandom_range(0, 1) ? clb_pkg::CH_SPACE : clb_pkg::CH_TAB;
    endfunction

    // Backslash and then one to three octal digits, or a single other byte.
    task automatic send_escape();
        int digits;
        int i;
        send_beat(clb_pkg::CH_BSLASH, 1'b0);
        digits = $urandom_range(0, 3);
        if (digits == 0)
            send_beat(8'($urandom_range(0, 255)), 1'b0);
        for (i = 0; i < digits; i++)
            send_beat(clb_pkg::CH_ZERO + 8'($urandom_range(0, 7)), 1'b0);
    endtask

    // One piece of plausible C source, or noise / a broken literal now and then.
    task automatic send_random_token();
        int n;
        int i;
        case ($urandom_range(0, 15))
            0, 1, 2:
            begin
                n = $urandom_range(1, 6);
                for (i = 0; i < n; i++)
                    send_beat(word_byte(), 1'b0);
            end
            3:
            begin
                case ($urandom_range(0, 4))
                    0:       send_beat(clb_pkg::CH_SEMI, 1'b0);
                    1:       send_beat(clb_pkg::CH_COLON, 1'b0);
                    2:       send_beat(clb_pkg::CH_QMARK, 1'b0);
                    3:       send_beat(clb_pkg::CH_RBRACE, 1'b0);
                    default: send_beat(clb_pkg::CH_LBRACE, 1'b0);
                endcase
            end
            4:
            begin
                send_beat(clb_pkg::CH_COMMA, 1'b0);
                n = $urandom_range(0, 3);
                for (i = 0; i < n; i++)
                    send_beat(blank_byte(), 1'b0);
                if ($urandom_range(0, 3) == 0)
                    send_beat(clb_pkg::CH_LF, 1'b0);
            end
            5, 6:
            begin
                send_beat(clb_pkg::CH_DQUOTE, 1'b0);
                n = $urandom_range(0, 5);
                for (i = 0; i < n; i++)
                begin
                    if ($urandom_range(0, 3) == 0)
                        send_escape();
                    else
                        send_beat($urandom_range(0, 4) ? word_byte() : clb_pkg::CH_SPACE,
                                  1'b0);
                end
                send_beat(clb_pkg::CH_DQUOTE, 1'b0);
            end
            7:
            begin
                send_beat(clb_pkg::CH_SQUOTE, 1'b0);
                if ($urandom_range(0, 1))
                    send_escape();
                else
                    send_beat(word_byte(), 1'b0);
                send_beat(clb_pkg::CH_SQUOTE, 1'b0);
            end
            8:
            begin
                n = $urandom_range(1, 3);
                for (i = 0; i < n; i++)
                    send_beat($urandom_range(0, 3) ? clb_pkg::CH_LF : clb_pkg::CH_FF, 1'b0);
            end
            9:
            begin
                // preprocessor line
                send_beat(clb_pkg::CH_LF, 1'b0);
                send_beat(clb_pkg::CH_HASH, 1'b0);
                n = $urandom_range(0, 5);
                for (i = 0; i < n; i++)
                    send_beat(word_byte(), 1'b0);
                send_beat(clb_pkg::CH_LF, 1'b0);
            end
            10:
                send_beat(blank_byte(), 1'b0);
            11, 12:
            begin
                n = $urandom_range(1, 3);
                for (i = 0; i < n; i++)
                    send_beat(8'($urandom_range(0, 255)), 1'b0);
            end
            13, 14:
            begin
                // broken literal: odd bodies, newlines, missing closers
                send_beat($urandom_range(0, 1) ? clb_pkg::CH_SQUOTE : clb_pkg::CH_DQUOTE,
                          1'b0);
                n = $urandom_range(1, 3);
                for (i = 0; i < n; i++)
                begin
                    case ($urandom_range(0, 4))
                        0:       send_beat(clb_pkg::CH_LF, 1'b0);
                        1:       send_beat(clb_pkg::CH_SQUOTE, 1'b0);
                        2:       send_beat(clb_pkg::CH_BSLASH, 1'b0);
                        3:       send_beat(clb_pkg::CH_DQUOTE, 1'b0);
                        default: send_beat(word_byte(), 1'b0);
                    endcase
                end
            end
            default:
            begin
                if ($urandom_range(0, 2) == 0)
                    end_stream();
                else
                    send_beat(word_byte(), 1'b0);
            end
        endcase
    endtask

    // ---------------------------------------------------------------
    // Tests.
    // ---------------------------------------------------------------

    // Breaks after ; : ? }, brace placement, dropped form feed and blank
    // line, discarded and kept '#', byte extremes, plain end of stream.
    task automatic test_layout();
        idle_on = 1'b0;
        send_text("x;{a{?:}");
        send_beat(clb_pkg::CH_FF, 1'b0);
        send_text("\n#d\nz#\n");
        send_beat(8'h00, 1'b0);
        send_beat(8'hFF, 1'b0);
        end_stream();
    endtask

    // Blank squeeze after a comma, comma before a newline, end right after one.
    task automatic test_comma_squeeze();
        idle_on = 1'b1;
        send_text("q, \t'\\101'");
        send_text(",\nw,");
        end_stream();
    endtask

    // Char literals: newline first, empty, unclosed, one- and two-digit and non-octal escapes.
    task automatic test_char_literals();
        send_text("'\n''");
        send_text("'\\7x'\\q''\\12''ab");
        end_stream();
    endtask

    // Strings: three-digit escape, non-octal escape, short escape ended by
    // the closing quote, newline inside, then a '#' line cut by end of stream.
    task automatic test_string_literals();
        idle_on = 1'b0;
        send_text("\"s\\0123\\9\\1\"\"\n#k");
        end_stream();
    endtask

    // End of stream inside every literal mode, and twice in a row.
    task automatic test_stream_end();
        idle_on = 1'b1;
        send_text("'");
        end_stream();
        send_text("'\\");
        end_stream();
        send_text("'a");
        end_stream();
        send_text("\"");
        end_stream();
        send_text("\"\\");
        end_stream();
        end_stream();
    endtask

    // Mostly well-formed source with random content; idling toggled in stretches.
    task automatic test_random_source(input int count);
        int stop_at;
        int next_flip;
        stop_at = items_sent + count;
        next_flip = items_sent;
        while (items_sent < stop_at)
        begin
            if (items_sent >= next_flip)
            begin
                idle_on = ($urandom_range(0, 3) != 0);
                next_flip = items_sent + $urandom_range(20, 60);
            end
            send_random_token();
        end
        end_stream();
    endtask

    // Wait for every predicted beat (up to DRAIN_LIMIT), then watch for stray ones.
    task automatic drain();
        int waited;
        waited = 0;
        while (pending_fmt.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (10) @(posedge clk);
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        test_layout();
        test_comma_squeeze();
        test_char_literals();
        test_string_literals();
        test_stream_end();
        test_random_source(RANDOM_BEATS);
        src_valid <= 1'b0;
        drain();
        if (pending_fmt.size() != 0)
        begin
            $error("%0d formatted beats never arrived", pending_fmt.size());
            fails++;
        end
        if (fails == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        #RUN_LIMIT;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
